// ===== hdl/reservoir_pick_matching_index_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the reservoir index picker
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RESERVOIR_PICK_MATCHING_INDEX_ASSERT_SVH
`define RESERVOIR_PICK_MATCHING_INDEX_ASSERT_SVH

`ifndef SYNTHESIS

`define RPMI_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define RPMI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RPMI_ASSERT_SAME(label, ante, cons, msg)

`define RPMI_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== hdl/rpmi_pkg.sv =====
// ----------------------------------------------------------------------------
// rpmi_pkg
// Shared types and constants of the reservoir index picker.
// ----------------------------------------------------------------------------
`default_nettype none

package rpmi_pkg;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_PICK   = 2'd2;

  typedef enum logic [1:0] {
    KIND_APPEND,
    KIND_CLEAR,
    KIND_PICK,
    KIND_NOP
  } rpmi_kind_t;

  localparam int KIND_W = 2;

  localparam int IDX_W = 11;
  localparam logic signed [IDX_W-1:0] NO_INDEX = -11'sd1;

  localparam int          RAND_W     = 31;
  localparam logic [31:0] LFSR_TAPS  = 32'hD000_0001;
  localparam logic [31:0] SEED_RESET = 32'd1;

  localparam logic REG_SEED = 1'b0;

  localparam int QUEUE_DEPTH = 2;
  localparam int QLEVEL_W    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic table_full;
    logic table_empty;
  } rpmi_back_stat_t;

endpackage

`default_nettype wire

// ===== hdl/rpmi_channels_if.sv =====
// ----------------------------------------------------------------------------
// rpmi channel interfaces
// Valid/ready channels for requests into and results out of the picker.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpmi_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [31:0] value;
  logic signed [31:0] target;

  modport source (output valid, output op, output value, output target, input ready);
  modport sink   (input valid, input op, input value, input target, output ready);
endinterface

interface rpmi_out_if;
  logic               valid;
  logic               ready;
  logic signed [10:0] index;
  logic               found;
  logic               status;

  modport source (output valid, output index, output found, output status, input ready);
  modport sink   (input valid, input index, input found, input status, output ready);
endinterface

`default_nettype wire

// ===== hdl/rpmi_front.sv =====
// ----------------------------------------------------------------------------
// rpmi_front
// Accepts requests, decodes the operation and forms the stored operand.
// ----------------------------------------------------------------------------
`default_nettype none

module rpmi_front #(
  parameter int VALUE_WIDTH = 32
) (
  rpmi_in_if.sink                      in_ch,
  input  wire logic                    q_full,
  output logic                         push,
  output logic [rpmi_pkg::KIND_W+VALUE_WIDTH-1:0] push_data
);
  import rpmi_pkg::*;

  rpmi_kind_t               kind;
  logic signed [31:0]       raw;
  logic [VALUE_WIDTH-1:0]   operand;

  always_comb begin
    unique case (in_ch.op)
      OP_APPEND: kind = KIND_APPEND;
      OP_CLEAR:  kind = KIND_CLEAR;
      OP_PICK:   kind = KIND_PICK;
      default:   kind = KIND_NOP;
    endcase
    raw     = (kind == KIND_PICK) ? in_ch.target : in_ch.value;
    operand = VALUE_WIDTH'(raw);
  end

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;
  assign push_data   = {kind, operand};

endmodule

`default_nettype wire

// ===== hdl/rpmi_queue.sv =====
// ----------------------------------------------------------------------------
// rpmi_queue
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module rpmi_queue #(
  parameter int WIDTH = 34
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  input  wire logic [WIDTH-1:0]              push_data,
  input  wire logic                          pop,
  output logic                               full,
  output logic                               valid,
  output logic [WIDTH-1:0]                   data,
  output logic [rpmi_pkg::QLEVEL_W-1:0]      level
);
  import rpmi_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic [WIDTH-1:0]    slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QLEVEL_W-1:0] level_r, level_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    level_nxt  = level_r + QLEVEL_W'(push) - QLEVEL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
    wr_ptr_r <= wr_ptr_nxt;
    rd_ptr_r <= rd_ptr_nxt;
    level_r  <= level_nxt;
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end
  end

  assign full  = (level_r == QLEVEL_W'(QUEUE_DEPTH));
  assign valid = (level_r != '0);
  assign data  = slot_r[rd_ptr_r];
  assign level = level_r;

endmodule

`default_nettype wire

// ===== hdl/rpmi_rem_unit.sv =====
// ----------------------------------------------------------------------------
// rpmi_rem_unit
// Bit-serial remainder of the random draw by the match count, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rpmi_rem_unit #(
  parameter int DIVISOR_WIDTH = 11
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [rpmi_pkg::RAND_W-1:0] dividend,
  input  wire logic [DIVISOR_WIDTH-1:0]    divisor,
  output logic                             done,
  output logic                             rem_zero
);
  import rpmi_pkg::*;

  localparam int STEP_W = $clog2(RAND_W);

  logic                     run_r, run_nxt;
  logic                     done_r, done_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic [RAND_W-1:0]        dvd_r, dvd_nxt;
  logic [DIVISOR_WIDTH-1:0] rem_r, rem_nxt;
  logic [DIVISOR_WIDTH:0]   trial;
  logic [DIVISOR_WIDTH:0]   dvs_ext;

  always_comb begin
    trial    = {rem_r, dvd_r[RAND_W-1]};
    dvs_ext  = {1'b0, divisor};
    run_nxt  = run_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    if (start) begin
      run_nxt  = 1'b1;
      step_nxt = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
    end else if (run_r) begin
      step_nxt = step_r + STEP_W'(1);
      dvd_nxt  = {dvd_r[RAND_W-2:0], 1'b0};
      rem_nxt  = (trial >= dvs_ext) ? DIVISOR_WIDTH'(trial - dvs_ext) : DIVISOR_WIDTH'(trial);
      if (step_r == STEP_W'(RAND_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    run_r  <= run_nxt;
    done_r <= done_nxt;
    step_r <= step_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end
  end

  assign done     = done_r;
  assign rem_zero = (rem_r == '0);

endmodule

`default_nettype wire

// ===== hdl/rpmi_back.sv =====
// ----------------------------------------------------------------------------
// rpmi_back
// Carries out queued requests: table writes, clear, and the reservoir scan.
// ----------------------------------------------------------------------------
`default_nettype none

module rpmi_back #(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic [31:0]                           seed,
  input  wire logic                                  cmd_valid,
  input  wire logic [rpmi_pkg::KIND_W+VALUE_WIDTH-1:0] cmd_data,
  output logic                                       cmd_pop,
  output rpmi_pkg::rpmi_back_stat_t                  stat,
  rpmi_out_if.source                                 out_ch
);
  import rpmi_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CW-1:0]          fill_r, fill_nxt;
  logic [31:0]            lfsr_r, lfsr_nxt;
  logic [AW-1:0]          idx_r, idx_nxt;
  logic [AW-1:0]          cand_r, cand_nxt;
  logic [AW-1:0]          kept_r, kept_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic                   found_r, found_nxt;
  logic                   last_r, last_nxt;
  logic [VALUE_WIDTH-1:0] target_r, target_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic signed [IDX_W-1:0] out_index_r, out_index_nxt;
  logic                   out_found_r, out_found_nxt;
  logic                   out_status_r, out_status_nxt;

  logic [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0] rd_data_r;
  logic                   wr_en;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;

  rpmi_kind_t             cmd_kind;
  logic [VALUE_WIDTH-1:0] cmd_operand;
  logic                   out_free;
  logic                   full;
  logic                   last;
  logic [31:0]            lfsr_step;
  logic [31:0]            seed_val;
  logic                   div_start;
  logic                   div_done;
  logic                   div_zero;

  assign cmd_kind    = rpmi_kind_t'(cmd_data[KIND_W+VALUE_WIDTH-1:VALUE_WIDTH]);
  assign cmd_operand = cmd_data[VALUE_WIDTH-1:0];
  assign out_free    = !out_valid_r || out_ch.ready;
  assign full        = (fill_r == CW'(TABLE_DEPTH));
  assign last        = ((CW'(idx_r) + CW'(1)) == fill_r);
  assign lfsr_step   = lfsr_r[0] ? ((lfsr_r >> 1) ^ LFSR_TAPS) : (lfsr_r >> 1);
  assign seed_val    = (seed == '0) ? SEED_RESET : seed;

  rpmi_rem_unit #(
    .DIVISOR_WIDTH(CW)
  ) u_rem (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(lfsr_step[RAND_W-1:0]),
    .divisor (count_nxt),
    .done    (div_done),
    .rem_zero(div_zero)
  );

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    lfsr_nxt       = lfsr_r;
    idx_nxt        = idx_r;
    cand_nxt       = cand_r;
    kept_nxt       = kept_r;
    count_nxt      = count_r;
    found_nxt      = found_r;
    last_nxt       = last_r;
    target_nxt     = target_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_index_nxt  = out_index_r;
    out_found_nxt  = out_found_r;
    out_status_nxt = out_status_r;
    cmd_pop        = 1'b0;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = idx_r + AW'(1);
    div_start      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop        = 1'b1;
          out_index_nxt  = NO_INDEX;
          out_found_nxt  = 1'b0;
          out_status_nxt = 1'b0;
          unique case (cmd_kind)
            KIND_APPEND: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_status_nxt = 1'b1;
              end else begin
                wr_en    = 1'b1;
                fill_nxt = fill_r + CW'(1);
              end
            end
            KIND_CLEAR: begin
              out_valid_nxt = 1'b1;
              fill_nxt      = '0;
              lfsr_nxt      = seed_val;
            end
            KIND_PICK: begin
              target_nxt = cmd_operand;
              count_nxt  = '0;
              found_nxt  = 1'b0;
              idx_nxt    = '0;
              if (fill_r == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                state_nxt = S_SCAN;
              end
            end
            KIND_NOP: begin
              out_valid_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        rd_en    = !last;
        idx_nxt  = idx_r + AW'(1);
        last_nxt = last;
        if (rd_data_r == target_r) begin
          count_nxt = count_r + CW'(1);
          lfsr_nxt  = lfsr_step;
          cand_nxt  = idx_r;
          found_nxt = 1'b1;
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else if (last) begin
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (div_zero) begin
            kept_nxt = cand_r;
          end
          state_nxt = last_r ? S_DONE : S_SCAN;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_index_nxt  = found_r ? IDX_W'(kept_r) : NO_INDEX;
          out_found_nxt  = found_r;
          out_status_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill_r[AW-1:0]] <= cmd_operand;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    state_r      <= state_nxt;
    fill_r       <= fill_nxt;
    lfsr_r       <= lfsr_nxt;
    idx_r        <= idx_nxt;
    cand_r       <= cand_nxt;
    kept_r       <= kept_nxt;
    count_r      <= count_nxt;
    found_r      <= found_nxt;
    last_r       <= last_nxt;
    target_r     <= target_nxt;
    out_valid_r  <= out_valid_nxt;
    out_index_r  <= out_index_nxt;
    out_found_r  <= out_found_nxt;
    out_status_r <= out_status_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      lfsr_r      <= SEED_RESET;
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.index  = out_index_r;
  assign out_ch.found  = out_found_r;
  assign out_ch.status = out_status_r;

  assign stat.table_full  = full;
  assign stat.table_empty = (fill_r == '0);

endmodule

`default_nettype wire

// ===== hdl/reservoir_pick_matching_index.sv =====
// Append, clear and unused requests are queued, then the back registers their result.
// Pick: the scan reads one table entry a cycle from the single read port of the table,
// pausing at each match while the 31-step remainder unit runs.
// Throughput: one request at a time in the back; up to two more wait in the queue.
// Reset (synchronous, rst_n low): table empty, seed register and generator set to 1,
// queue and result register empty; table contents are left as they are.
`default_nettype none

`include "reservoir_pick_matching_index_assert.svh"

// ----------------------------------------------------------------------------
// reservoir_pick_matching_index
// Table of values with append, clear and a reservoir-sampled pick of a match.
// ----------------------------------------------------------------------------
module reservoir_pick_matching_index #(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  rpmi_in_if.sink          in_ch,
  rpmi_out_if.source       out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import rpmi_pkg::*;

  localparam int QW = KIND_W + VALUE_WIDTH;

  logic [31:0]         seed_r, seed_nxt;
  logic                cfg_wr;
  logic                q_push;
  logic [QW-1:0]       q_push_data;
  logic                q_pop;
  logic                q_full;
  logic                q_valid;
  logic [QW-1:0]       q_data;
  logic [QLEVEL_W-1:0] q_level;
  rpmi_back_stat_t     back_st;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_SEED) ? seed_r : '0;

  always_comb begin
    seed_nxt = seed_r;
    if (cfg_wr && (cfg_paddr[2] == REG_SEED)) begin
      seed_nxt = cfg_pwdata;
    end
  end

  always_ff @(posedge clk) begin
    seed_r <= seed_nxt;
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end
  end

  rpmi_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (q_push),
    .push_data(q_push_data)
  );

  rpmi_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_push_data),
    .pop      (q_pop),
    .full     (q_full),
    .valid    (q_valid),
    .data     (q_data),
    .level    (q_level)
  );

  rpmi_back #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .seed     (seed_r),
    .cmd_valid(q_valid),
    .cmd_data (q_data),
    .cmd_pop  (q_pop),
    .stat     (back_st),
    .out_ch   (out_ch)
  );

  `RPMI_ASSERT_NEXT(a_accept_queued, in_ch.valid && in_ch.ready, q_level != '0, "accepted request lost from queue")
  `RPMI_ASSERT_SAME(a_full_no_ready, q_level == QLEVEL_W'(QUEUE_DEPTH), !in_ch.ready, "ready high with queue full")
  `RPMI_ASSERT_SAME(a_refused_full, out_ch.valid && out_ch.status, back_st.table_full, "refusal shown with room in table")
  `RPMI_ASSERT_SAME(a_found_nonempty, out_ch.valid && out_ch.found, !back_st.table_empty, "match reported from empty table")

endmodule

`default_nettype wire
